### sv/svf2x_pkg.sv
// Shared types, widths and constants for the 2x oversampled state variable filter.
`default_nettype none

package svf2x_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 18;
  localparam int ACC_W     = 32;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CFG   = 4;
  localparam int TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;

  // product of a signed operand and a zero-extended coefficient
  localparam int PROD_W = ACC_W + COEF_W + 1;
  localparam int RND_SH = COEF_W - 1;
  localparam int TERM_W = PROD_W - RND_SH;
  localparam int SUM_W  = ACC_W + 4;

  localparam int OP_CNT_W = 3;
  localparam logic [OP_CNT_W-1:0] LAST_OP = OP_CNT_W'(6);

  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (RND_SH - 1);

  localparam logic signed [SUM_W-1:0] ACC_MAX_S =
    {{(SUM_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN_S = ~ACC_MAX_S;
  localparam logic signed [SUM_W-1:0] OUT_MAX_S =
    {{(SUM_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] OUT_MIN_S = ~OUT_MAX_S;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = CFG_IDX_W'(3);

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << (COEF_W - 1);

  typedef enum logic [1:0] {
    OP_SCALE,
    OP_LOW,
    OP_HIGH,
    OP_BAND
  } op_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_BAND,
    MODE_LOW,
    MODE_HIGH,
    MODE_NOTCH
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_ACC,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic rnd_en;
    logic acc_en;
    op_e  op;
    logic out_en;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

  // input scaling, then two passes of low / high / band
  function automatic op_e op_of(input logic [OP_CNT_W-1:0] cnt);
    op_e op;
    case (cnt) inside
      OP_CNT_W'(0):               op = OP_SCALE;
      OP_CNT_W'(1), OP_CNT_W'(4): op = OP_LOW;
      OP_CNT_W'(2), OP_CNT_W'(5): op = OP_HIGH;
      default:                    op = OP_BAND;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

### sv/svf2x_ctrl.sv
// Sequencer: steps the shared multiplier through the seven products of one item.
`default_nettype none

module svf2x_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire svf2x_pkg::sts_t sts_i,
  output svf2x_pkg::cmd_t     cmd_o
);
  import svf2x_pkg::*;

  state_e                state_q, state_d;
  logic [OP_CNT_W-1:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.op   = op_of(cnt_q);
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_RND;
      end
      ST_RND: begin
        cmd_o.rnd_en = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (cnt_q == LAST_OP) begin
          state_d = ST_OUT;
        end else begin
          cnt_d   = cnt_q + OP_CNT_W'(1);
          state_d = ST_MUL;
        end
      end
      ST_OUT: begin
        if (!sts_i.out_full) begin
          cmd_o.out_en = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while previous one still in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LAST_OP)
    else $error("op counter ran past last product");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_en |-> $past(cmd_o.acc_en) || (state_q == ST_OUT))
    else $error("result written without finishing the products");

endmodule

`default_nettype wire

### sv/svf2x_dp.sv
// Datapath: coefficient registers, shared multiplier, rounding, integrators, output register.
`default_nettype none

module svf2x_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [svf2x_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [svf2x_pkg::COEF_W-1:0]         cfg_data_i,
  input  wire logic signed [svf2x_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                                 last_i,
  input  wire svf2x_pkg::cmd_t                      cmd_i,
  output svf2x_pkg::sts_t                           sts_o,
  input  wire logic                                 out_ready_i,
  output logic                                      out_valid_o,
  output logic [svf2x_pkg::SAMPLE_W-1:0]            out_data_o,
  output logic                                      out_clip_o,
  output logic                                      out_last_o
);
  import svf2x_pkg::*;

  logic [COEF_W-1:0]         freq_q, damp_q, gain_q;
  mode_e                     mode_q;
  logic signed [ACC_W-1:0]   low_q, band_q, high_q;
  logic signed [TERM_W-1:0]  scaled_q, term_q, term_d;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                      last_q, clip_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic [SAMPLE_W-1:0]       out_data_q, out_data_d;
  logic                      out_clip_q, out_last_q, out_valid_q;

  logic                      cfg_hit;
  logic signed [ACC_W-1:0]   opa;
  logic [COEF_W-1:0]         coef;
  logic signed [COEF_W:0]    coef_s;
  logic [PROD_W-1:0]         rnd_sum;
  logic signed [SUM_W-1:0]   term_x, low_x, band_x, high_x, scaled_x, sum_x, sel_x;
  logic signed [ACC_W-1:0]   sat_val;
  logic                      sat_hit, out_sat;

  assign cfg_hit = cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_CFG));

  // multiplier operands
  always_comb begin
    case (cmd_i.op)
      OP_SCALE: begin opa = ACC_W'(sample_q); coef = gain_q; end
      OP_LOW:   begin opa = band_q;           coef = freq_q; end
      OP_HIGH:  begin opa = band_q;           coef = damp_q; end
      OP_BAND:  begin opa = high_q;           coef = freq_q; end
      default:  begin opa = band_q;           coef = freq_q; end
    endcase
  end

  assign coef_s = $signed({1'b0, coef});
  assign prod_d = PROD_W'(opa) * PROD_W'(coef_s);

  // round half away from zero: negative products get one less bias
  assign rnd_sum = prod_q + RND_HALF - PROD_W'(prod_q[PROD_W-1]);
  assign term_d  = $signed(rnd_sum[RND_SH +: TERM_W]);

  assign term_x   = SUM_W'(term_q);
  assign low_x    = SUM_W'(low_q);
  assign band_x   = SUM_W'(band_q);
  assign high_x   = SUM_W'(high_q);
  assign scaled_x = SUM_W'(scaled_q);

  always_comb begin
    case (cmd_i.op)
      OP_LOW:  sum_x = low_x + term_x;
      OP_HIGH: sum_x = scaled_x - low_x - term_x;
      OP_BAND: sum_x = band_x + term_x;
      default: sum_x = term_x;
    endcase
    sat_hit = 1'b0;
    if (sum_x > ACC_MAX_S) begin
      sat_val = ACC_MAX_S[ACC_W-1:0];
      sat_hit = 1'b1;
    end else if (sum_x < ACC_MIN_S) begin
      sat_val = ACC_MIN_S[ACC_W-1:0];
      sat_hit = 1'b1;
    end else begin
      sat_val = sum_x[ACC_W-1:0];
    end
  end

  always_comb begin
    case (mode_q)
      MODE_BAND:  sel_x = band_x;
      MODE_LOW:   sel_x = low_x;
      MODE_HIGH:  sel_x = high_x;
      MODE_NOTCH: sel_x = high_x + low_x;
      default:    sel_x = low_x;
    endcase
    out_sat = 1'b0;
    if (sel_x > OUT_MAX_S) begin
      out_data_d = OUT_MAX_S[SAMPLE_W-1:0];
      out_sat    = 1'b1;
    end else if (sel_x < OUT_MIN_S) begin
      out_data_d = OUT_MIN_S[SAMPLE_W-1:0];
      out_sat    = 1'b1;
    end else begin
      out_data_d = sel_x[SAMPLE_W-1:0];
    end
  end

  // control state, coefficients and integrators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q      <= '0;
      damp_q      <= COEF_ONE;
      gain_q      <= COEF_ONE;
      mode_q      <= MODE_LOW;
      low_q       <= '0;
      band_q      <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FREQ: freq_q <= cfg_data_i;
          CFG_DAMP: damp_q <= cfg_data_i;
          CFG_GAIN: gain_q <= cfg_data_i;
          CFG_MODE: mode_q <= mode_e'(cfg_data_i[MODE_W-1:0]);
          default: ;
        endcase
      end
      if (cfg_hit) begin
        low_q  <= '0;
        band_q <= '0;
      end else if (cmd_i.acc_en) begin
        case (cmd_i.op)
          OP_LOW:  low_q  <= sat_val;
          OP_BAND: band_q <= sat_val;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        clip_q <= 1'b0;
      end else if (cmd_i.acc_en && sat_hit) begin
        clip_q <= 1'b1;
      end
      if (cmd_i.out_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
      last_q   <= last_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.rnd_en) begin
      term_q <= term_d;
    end
    if (cmd_i.acc_en) begin
      case (cmd_i.op)
        OP_SCALE: scaled_q <= term_q;
        OP_HIGH:  high_q   <= sat_val;
        default: ;
      endcase
    end
    if (cmd_i.out_en) begin
      out_data_q <= out_data_d;
      out_clip_q <= clip_q || out_sat;
      out_last_q <= last_q;
    end
  end

  assign sts_o.out_full = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign out_clip_o     = out_clip_q;
  assign out_last_o     = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (low_q == '0) && (band_q == '0))
    else $error("register write did not clear the integrators");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.out_en))
    else $error("result appeared without a write command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_en |-> !(out_valid_q && !out_ready_i))
    else $error("result register overwritten while still held");

endmodule

`default_nettype wire

### sv/state_variable_filter_2x_top.sv
// Top level: 2x oversampled state variable filter with stream ports and register write port.
// Each item runs 7 products, each through multiply, round and accumulate, then the output state.
// One item at a time on the single shared 32x19 multiplier; a new item is accepted only in idle.
// A result waiting in the output register does not block the next item; a result still
// held when the next one finishes stalls the sequencer until the downstream side takes it.
// Reset: asynchronous, active low; integrators clear, coefficients 0 / 1.0 / 1.0, mode low.
`default_nettype none

module state_variable_filter_2x_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // register write port
  input  wire logic                             cfg_we_i,
  input  wire logic [svf2x_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [svf2x_pkg::COEF_W-1:0]     cfg_data_i,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [svf2x_pkg::TDATA_W-1:0]    s_axis_tdata,  // sample_in
  input  wire logic                             s_axis_tlast,  // frame_end_in
  // output stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [svf2x_pkg::TDATA_W-1:0]         m_axis_tdata,  // filter_out
  output logic                                  m_axis_tuser,  // clipped
  output logic                                  m_axis_tlast   // frame_end_out
);
  import svf2x_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic [SAMPLE_W-1:0] out_data;

  svf2x_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  svf2x_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    ($signed(s_axis_tdata[SAMPLE_W-1:0])),
    .last_i      (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_data),
    .out_clip_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = TDATA_W'(out_data);

endmodule

`default_nettype wire

### dv/state_variable_filter_2x_top_tb.sv
// Self-checking testbench for the 2x oversampled state variable filter top level.
`timescale 1ns / 1ps

module state_variable_filter_2x_top_tb;
  import svf2x_pkg::*;

  localparam logic [SAMPLE_W-1:0] SMP_MAX  = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SMP_MIN  = {1'b1, {(SAMPLE_W - 1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] SMP_ZERO = '0;
  localparam logic [SAMPLE_W-1:0] SMP_NEG1 = '1;
  localparam logic [SAMPLE_W-1:0] SMP_POS1 = SAMPLE_W'(1);
  localparam logic [COEF_W-1:0]   COEF_MAX = '1;
  localparam int                  TOTAL_ITEMS = 1225;
  localparam int                  DRAIN_CYCLES = 50;

  typedef struct {
    logic [SAMPLE_W-1:0] out;
    logic                clip;
    logic                last;
  } filt_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [COEF_W-1:0]    cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata;   // sample_in
  logic                 s_axis_tlast;   // frame_end_in
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [TDATA_W-1:0]   m_axis_tdata;   // filter_out
  logic                 m_axis_tuser;   // clipped
  logic                 m_axis_tlast;   // frame_end_out

  state_variable_filter_2x_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  class svf_scoreboard;
    longint       freq;
    longint       damp;
    longint       gain;
    mode_e        mode;
    longint       low_acc;
    longint       band_acc;
    bit           clip_hit;
    filt_result_t expected_q[$];
    int           mismatches;
    int           checked;
    int           clipped_seen;

    function new();
      freq     = 0;
      damp     = longint'(COEF_ONE);
      gain     = longint'(COEF_ONE);
      mode     = MODE_LOW;
      low_acc  = 0;
      band_acc = 0;
      mismatches   = 0;
      checked      = 0;
      clipped_seen = 0;
    endfunction

    // a * c / 2^(COEF_W-1), rounded half away from zero
    function longint coef_mul(longint a, longint c);
      longint m;
      longint r;
      m = (a < 0) ? -a : a;
      r = (m * c + (longint'(1) << (RND_SH - 1))) >>> RND_SH;
      return (a < 0) ? -r : r;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v > hi) begin
        clip_hit = 1'b1;
        return hi;
      end
      if (v < lo) begin
        clip_hit = 1'b1;
        return lo;
      end
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
      case (idx)
        CFG_FREQ: freq = longint'(val);
        CFG_DAMP: damp = longint'(val);
        CFG_GAIN: gain = longint'(val);
        CFG_MODE: mode = mode_e'(val[MODE_W-1:0]);
        default:  return;
      endcase
      low_acc  = 0;
      band_acc = 0;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] smp, logic fe);
      longint       acc_max;
      longint       acc_min;
      longint       out_max;
      longint       out_min;
      longint       x;
      longint       scaled;
      longint       hp;
      longint       sel;
      filt_result_t r;
      acc_max  = (longint'(1) << (ACC_W - 1)) - 1;
      acc_min  = -acc_max - 1;
      out_max  = (longint'(1) << (SAMPLE_W - 1)) - 1;
      out_min  = -out_max - 1;
      x        = longint'(smp);
      clip_hit = 1'b0;
      hp       = 0;
      scaled   = coef_mul(x, gain);
      repeat (2) begin
        low_acc  = clamp(low_acc + coef_mul(band_acc, freq), acc_min, acc_max);
        hp       = clamp(scaled - low_acc - coef_mul(band_acc, damp), acc_min, acc_max);
        band_acc = clamp(band_acc + coef_mul(hp, freq), acc_min, acc_max);
      end
      case (mode)
        MODE_BAND: sel = band_acc;
        MODE_LOW:  sel = low_acc;
        MODE_HIGH: sel = hp;
        default:   sel = hp + low_acc;
      endcase
      sel    = clamp(sel, out_min, out_max);
      r.out  = SAMPLE_W'(sel);
      r.clip = clip_hit;
      r.last = fe;
      expected_q.push_back(r);
    endfunction

    function void check_output(logic [TDATA_W-1:0] data, logic user, logic last);
      filt_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, data %0d", $time, $signed(data[SAMPLE_W-1:0]));
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (user) clipped_seen++;
      if (data[SAMPLE_W-1:0] !== e.out) begin
        $display("%0t: filter_out mismatch, expected %0d, actual %0d", $time,
                 $signed(e.out), $signed(data[SAMPLE_W-1:0]));
        mismatches++;
      end
      if (user !== e.clip) begin
        $display("%0t: clipped mismatch, expected %0b, actual %0b", $time, e.clip, user);
        mismatches++;
      end
      if (last !== e.last) begin
        $display("%0t: frame_end mismatch, expected %0b, actual %0b", $time, e.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  svf_scoreboard sb;
  int            items_sent = 0;
  int            settings   = 0;
  bit            steady     = 1'b0;  // no idling on either side
  int            hold_req   = 0;     // long downstream hold-off, in cycles

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic fe);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= TDATA_W'($urandom);
      s_axis_tlast  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(smp);
    s_axis_tlast  <= fe;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(smp, fe);
    items_sent++;
  endtask

  // drop valid and wait until every expected result is back
  task automatic end_phase();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    settings++;
  endtask

  function automatic logic [COEF_W-1:0] pick_coef(int lo, int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 18) return COEF_ONE;
    if (r < 24) return COEF_MAX;
    return COEF_W'($urandom_range(lo, hi));
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    case (r % 5)
      0: if (r < 10) return SMP_MAX;
      1: if (r < 10) return SMP_MIN;
      2: if (r < 10) return SMP_ZERO;
      3: if (r < 10) return SMP_NEG1;
      default: ;
    endcase
    if (r < 35) return SAMPLE_W'($urandom);
    return SAMPLE_W'($urandom_range(0, 1 << 21) - (1 << 20));
  endfunction

  // downstream side
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_output(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  initial begin : run_limit
    #5_000_000;
    $display("%0t: timeout, %0d results still expected", $time, sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int     phase;
    int     n_items;
    mode_e  m;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients: freq 0 keeps integrators at zero
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b1);
    send_sample(SMP_ZERO, 1'b0);
    send_sample(SMP_NEG1, 1'b1);
    send_sample(SMP_POS1, 1'b0);
    end_phase();

    // coefficients near two, no damping: drives every saturation
    write_reg(CFG_FREQ, COEF_MAX);
    write_reg(CFG_DAMP, '0);
    write_reg(CFG_GAIN, COEF_MAX);
    write_reg(CFG_MODE, COEF_W'(MODE_NOTCH));
    repeat (4) send_sample(SMP_MAX, 1'b1);
    repeat (4) send_sample(SMP_MIN, 1'b0);
    end_phase();

    write_reg(CFG_FREQ, COEF_ONE);
    write_reg(CFG_DAMP, COEF_ONE);
    write_reg(CFG_GAIN, COEF_ONE);
    for (int k = 0; k < 3; k++) begin
      m = mode_e'(k);
      write_reg(CFG_MODE, COEF_W'(m));
      send_sample(SMP_MAX, 1'b0);
      send_sample(SMP_MIN, 1'b1);
      if (m == MODE_BAND) begin
        end_phase();
        // unlisted indexes must leave the integrators alone
        for (int i = NUM_CFG; i < (1 << CFG_IDX_W); i++)
          write_reg(CFG_IDX_W'(i), COEF_W'($urandom));
      end
      send_sample(SMP_POS1, 1'b0);
      end_phase();
    end

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      phase++;
      steady = (phase % 3 == 0);
      if ($urandom_range(0, 9) < 7) write_reg(CFG_FREQ, pick_coef(1, 40000));
      if ($urandom_range(0, 9) < 7) write_reg(CFG_DAMP, pick_coef(2000, (1 << COEF_W) - 1));
      if ($urandom_range(0, 9) < 7) write_reg(CFG_GAIN, pick_coef(0, int'(COEF_ONE)));
      if ($urandom_range(0, 9) < 7)
        write_reg(CFG_MODE, {(COEF_W - MODE_W)'($urandom), MODE_W'($urandom_range(0, 3))});
      if ($urandom_range(0, 6) == 0)
        write_reg(CFG_IDX_W'($urandom_range(NUM_CFG, (1 << CFG_IDX_W) - 1)), COEF_W'($urandom));
      // the sink holds off while items keep coming, so the block backs up
      if (phase % 4 == 1) hold_req = $urandom_range(200, 400);
      n_items = $urandom_range(20, 120);
      repeat (n_items) send_sample(pick_sample(), $urandom_range(0, 7) == 0);
      end_phase();
    end
    steady = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d samples across %0d register writes; %0d results checked, %0d clipped.",
             items_sent, settings, sb.checked, sb.clipped_seen);
    $display("All four output modes, coefficient extremes and long downstream stalls exercised.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
sv/svf2x_pkg.sv
sv/svf2x_ctrl.sv
sv/svf2x_dp.sv
sv/state_variable_filter_2x_top.sv
dv/state_variable_filter_2x_top_tb.sv
